/* design/thp_pkg.sv */
// Shared constants, tables and types of the trapezoidal heading profile block.
`timescale 1ns / 1ps
package thp_pkg;

  // Sample rate and CORDIC depth
  localparam int SAMPLE_RATE_HZ = 250;
  localparam int CORDIC_STEPS   = 16;
  localparam int CORDIC_ITERS   = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;

  // Q16.16 angle constants
  localparam int Q_PI         = 205887;
  localparam int Q_TWO_PI     = 411775;
  localparam int Q_HALF_PI    = 102944;
  localparam int ARRIVE_ANGLE = 655;
  localparam int ARRIVE_SPEED = 66;

  // CORDIC vector width and normalization threshold
  localparam int CW = 45;
  localparam logic [CW-1:0] NORM_LIMIT = CW'(64'd1 << 40);

  // Modulo reduction: bias to make the sum non-negative, then binary subtract steps
  localparam int MW = 35;
  localparam int MOD_STEPS = 15;
  localparam longint MOD_OFFSET = longint'(10431) * Q_TWO_PI + Q_PI;

  // Divide by the sample rate as a reciprocal multiply, exact for 32-bit operands
  localparam int DIV_W = 32;
  localparam int DIV_SHIFT = DIV_W + $clog2(SAMPLE_RATE_HZ);
  localparam logic [DIV_W:0] DIV_MAGIC =
    (DIV_W+1)'(((64'd1 << DIV_SHIFT) + 64'(SAMPLE_RATE_HZ) - 64'd1) / 64'(SAMPLE_RATE_HZ));

  // Sequencer count width
  localparam int CNT_W = 5;

  // Configuration register indexes
  localparam logic [1:0] CFG_MAX_SPEED = 2'd0;
  localparam logic [1:0] CFG_ACCEL     = 2'd1;
  localparam logic [1:0] CFG_GHOST_X   = 2'd2;
  localparam logic [1:0] CFG_GHOST_Y   = 2'd3;

  // Rounded arctangent of 2^-i in Q16.16
  function automatic logic [15:0] atan_entry(input logic [CNT_W-1:0] i);
    logic [15:0] v;
    unique case (i)
      5'd0:    v = 16'd51472;
      5'd1:    v = 16'd30386;
      5'd2:    v = 16'd16055;
      5'd3:    v = 16'd8150;
      5'd4:    v = 16'd4091;
      5'd5:    v = 16'd2047;
      5'd6:    v = 16'd1024;
      5'd7:    v = 16'd512;
      5'd8:    v = 16'd256;
      5'd9:    v = 16'd128;
      5'd10:   v = 16'd64;
      5'd11:   v = 16'd32;
      5'd12:   v = 16'd16;
      5'd13:   v = 16'd8;
      5'd14:   v = 16'd4;
      5'd15:   v = 16'd2;
      5'd16:   v = 16'd1;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIFF, ST_NORM, ST_CORDIC, ST_WRAP, ST_MOD, ST_ANGLE,
    ST_SIMPLE, ST_DIV, ST_MUL, ST_UPD, ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_DIFF, OP_ZERO, OP_DOUBLE, OP_PREROT, OP_CORDIC,
    OP_WRAP, OP_MOD, OP_ANGLE, OP_SIMPLE, OP_DIV, OP_MUL, OP_UPDATE, OP_PUBLISH
  } op_t;

  typedef struct packed {
    op_t             op;
    logic [CNT_W-1:0] step;
  } thp_cmd_t;

  typedef struct packed {
    logic xy_zero;
    logic norm_done;
    logic start_kind;
    logic rotating;
  } thp_status_t;

endpackage

/* design/thp_if.sv */
// Valid/ready channel interfaces for input items and result items.
`timescale 1ns / 1ps
interface thp_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [31:0] target_x;
  logic signed [31:0] target_y;
  modport source (output valid, kind, target_x, target_y, input ready);
  modport sink (input valid, kind, target_x, target_y, output ready);
endinterface

interface thp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] angular_speed_cmd;
  logic signed [31:0] heading;
  logic signed [18:0] angle_remaining;
  logic               busy_res;
  logic               arrived;
  modport source (output valid, angular_speed_cmd, heading, angle_remaining, busy_res,
                  arrived, input ready);
  modport sink (input valid, angular_speed_cmd, heading, angle_remaining, busy_res,
                arrived, output ready);
endinterface

/* design/thp_ctrl.sv */
// Sequencer that steps the datapath through bearing and wrap, then divide and update or the simple path.
`timescale 1ns / 1ps
module thp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  thp_pkg::thp_status_t status,
  output thp_pkg::thp_cmd_t    cmd
);
  import thp_pkg::*;

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             publish;

  // State, count and result valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (publish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Next state and datapath command
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd.op     = OP_NONE;
    cmd.step   = cnt;
    in_ready   = 1'b0;
    publish    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = ST_DIFF;
        end
      end
      ST_DIFF: begin
        cmd.op     = OP_DIFF;
        state_next = ST_NORM;
      end
      ST_NORM: begin
        priority if (status.xy_zero) begin
          cmd.op     = OP_ZERO;
          state_next = ST_WRAP;
        end else if (status.norm_done) begin
          cmd.op     = OP_PREROT;
          cnt_next   = '0;
          state_next = ST_CORDIC;
        end else begin
          cmd.op = OP_DOUBLE;
        end
      end
      ST_CORDIC: begin
        cmd.op = OP_CORDIC;
        if (cnt == CNT_W'(CORDIC_ITERS - 1)) begin
          state_next = ST_WRAP;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_WRAP: begin
        cmd.op     = OP_WRAP;
        cnt_next   = CNT_W'(MOD_STEPS - 1);
        state_next = ST_MOD;
      end
      ST_MOD: begin
        cmd.op = OP_MOD;
        if (cnt == '0) begin
          state_next = ST_ANGLE;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      ST_ANGLE: begin
        cmd.op   = OP_ANGLE;
        cnt_next = '0;
        if (status.start_kind || !status.rotating) begin
          state_next = ST_SIMPLE;
        end else begin
          state_next = ST_DIV;
        end
      end
      ST_SIMPLE: begin
        cmd.op     = OP_SIMPLE;
        state_next = ST_DONE;
      end
      ST_DIV: begin
        cmd.op     = OP_DIV;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.op     = OP_MUL;
        state_next = ST_UPD;
      end
      ST_UPD: begin
        cmd.op     = OP_UPDATE;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.op     = OP_PUBLISH;
          publish    = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* design/thp_datapath.sv */
// Registers, CORDIC, modulo, divider and speed profile update of the block.
`timescale 1ns / 1ps
module thp_datapath (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  thp_pkg::thp_cmd_t    cmd,
  output thp_pkg::thp_status_t status,
  input  logic                kind,
  input  logic signed [31:0]  target_x,
  input  logic signed [31:0]  target_y,
  output logic signed [31:0]  angular_speed_cmd,
  output logic signed [31:0]  heading,
  output logic signed [18:0]  angle_remaining,
  output logic                busy_res,
  output logic                arrived
);
  import thp_pkg::*;

  // Configuration and profile state
  logic [30:0]        max_speed;
  logic [30:0]        accel;
  logic signed [31:0] ghost_x, ghost_y;
  logic signed [31:0] head, speed, goal_x, goal_y;
  logic               rotating, start_kind;

  // Work registers
  logic signed [CW-1:0] cx, cy;
  logic signed [31:0]   cz;
  logic [MW-1:0]        mv;
  logic signed [18:0]   rem;
  logic [DIV_W-1:0]     dq_s, dq_a;
  logic [63:0]          ww, lim_prod;
  logic signed [31:0]   p_cmd;
  logic                 p_arrived;

  // Combinational helpers
  logic signed [32:0]   dx, dy;
  logic [CW-1:0]        ax, ay;
  logic signed [CW-1:0] xs, ys, at;
  logic signed [35:0]   wsum;
  logic [MW-1:0]        msub;
  logic [2*DIV_W:0]     qp_s, qp_a;
  logic [31:0]          spd_abs;
  logic [17:0]          ar;
  logic                 a_zero, w_zero, spz, ge, pos_ok, neg_ok, go_accel;
  logic signed [33:0]   s34, st34, lim34, up, dn, new34;
  logic signed [32:0]   inc, new_abs;
  logic signed [31:0]   head_new;
  logic                 arrive;

  always_comb begin
    dx      = {goal_x[31], goal_x} - {ghost_x[31], ghost_x};
    dy      = {goal_y[31], goal_y} - {ghost_y[31], ghost_y};
    ax      = cx[CW-1] ? CW'(-cx) : CW'(cx);
    ay      = cy[CW-1] ? CW'(-cy) : CW'(cy);
    xs      = cx >>> cmd.step;
    ys      = cy >>> cmd.step;
    at      = {{(CW-16){1'b0}}, atan_entry(cmd.step)};
    wsum    = {{4{cz[31]}}, cz} - {{4{head[31]}}, head} + 36'(MOD_OFFSET);
    msub    = MW'(Q_TWO_PI) << cmd.step;
    spd_abs = speed[31] ? 32'(-speed) : 32'(speed);
    ar      = rem[18] ? 18'(-rem) : 18'(rem);
    qp_s    = (2*DIV_W+1)'(spd_abs) * (2*DIV_W+1)'(DIV_MAGIC);
    qp_a    = (2*DIV_W+1)'(accel) * (2*DIV_W+1)'(DIV_MAGIC);
  end

  assign status.xy_zero    = (cx == '0) && (cy == '0);
  assign status.norm_done  = (ax >= NORM_LIMIT) || (ay >= NORM_LIMIT);
  assign status.start_kind = start_kind;
  assign status.rotating   = rotating;

  // Speed profile decision for a rotating tick
  always_comb begin
    a_zero   = (accel == '0);
    w_zero   = (spd_abs == '0);
    spz      = a_zero ? w_zero : (ww < {32'd0, accel, 1'b0});
    ge       = a_zero ? w_zero : (ww < lim_prod);
    pos_ok   = !speed[31] || spz;
    neg_ok   = speed[31] || spz;
    go_accel = ((pos_ok && !rem[18]) || (neg_ok && (rem[18] || rem == '0))) && ge;
    s34      = {{2{speed[31]}}, speed};
    st34     = {2'b00, dq_a};
    lim34    = {3'b000, max_speed};
    up       = s34 + st34;
    dn       = s34 - st34;
    inc      = speed[31] ? -$signed({1'b0, dq_s}) : $signed({1'b0, dq_s});
    if (go_accel) begin
      if (!rem[18] && rem != '0) begin
        new34 = (up > lim34) ? lim34 : up;
      end else begin
        new34 = (dn < -lim34) ? -lim34 : dn;
      end
    end else begin
      if (!speed[31] && speed != '0) begin
        new34 = dn[33] ? '0 : dn;
      end else if (speed[31]) begin
        new34 = (!up[33] && up != '0) ? '0 : up;
      end else begin
        new34 = s34;
      end
      if ({14'd0, ar} < dq_s) begin
        inc = {{14{rem[18]}}, rem};
      end
    end
    head_new = head + inc[31:0];
    new_abs  = new34[33] ? 33'(-new34) : 33'(new34);
    arrive   = (ar < 18'(ARRIVE_ANGLE)) && (new_abs < 33'(ARRIVE_SPEED));
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      max_speed <= 31'd131072;
      accel     <= 31'd327680;
      ghost_x   <= '0;
      ghost_y   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_SPEED: max_speed <= cfg_data[30:0];
        CFG_ACCEL:     accel     <= cfg_data[30:0];
        CFG_GHOST_X:   ghost_x   <= cfg_data;
        CFG_GHOST_Y:   ghost_y   <= cfg_data;
        default:       max_speed <= max_speed;
      endcase
    end
  end

  // Profile state
  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      speed    <= '0;
      goal_x   <= '0;
      goal_y   <= '0;
      rotating <= 1'b0;
    end else begin
      unique case (cmd.op)
        OP_LOAD: begin
          if (kind) begin
            goal_x   <= target_x;
            goal_y   <= target_y;
            rotating <= 1'b1;
          end
        end
        OP_SIMPLE: begin
          if (!start_kind) begin
            speed <= '0;
          end
        end
        OP_UPDATE: begin
          if (arrive) begin
            speed    <= '0;
            head     <= cz;
            rotating <= 1'b0;
          end else begin
            speed <= new34[31:0];
            head  <= head_new;
          end
        end
        default: begin
          head <= head;
        end
      endcase
    end
  end

  // Work registers, advanced one operation per cycle
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        start_kind <= kind;
      end
      OP_DIFF: begin
        cx <= {{(CW-33){dx[32]}}, dx};
        cy <= {{(CW-33){dy[32]}}, dy};
      end
      OP_ZERO: begin
        cz <= '0;
      end
      OP_DOUBLE: begin
        cx <= cx <<< 1;
        cy <= cy <<< 1;
      end
      OP_PREROT: begin
        if (cx[CW-1]) begin
          if (!cy[CW-1]) begin
            cx <= cy;
            cy <= -cx;
            cz <= 32'(Q_HALF_PI);
          end else begin
            cx <= -cy;
            cy <= cx;
            cz <= -32'(Q_HALF_PI);
          end
        end else begin
          cz <= '0;
        end
      end
      OP_CORDIC: begin
        if (!cy[CW-1] && cy != '0) begin
          cx <= cx + ys;
          cy <= cy - xs;
          cz <= cz + 32'(at);
        end else begin
          cx <= cx - ys;
          cy <= cy + xs;
          cz <= cz - 32'(at);
        end
      end
      OP_WRAP: begin
        mv <= MW'(wsum);
      end
      OP_MOD: begin
        if (mv >= msub) begin
          mv <= mv - msub;
        end
      end
      OP_ANGLE: begin
        rem <= $signed(mv[18:0] - 19'(Q_PI));
      end
      OP_SIMPLE: begin
        p_cmd     <= start_kind ? speed : '0;
        p_arrived <= 1'b0;
      end
      OP_DIV: begin
        dq_s <= DIV_W'(qp_s >> DIV_SHIFT);
        dq_a <= DIV_W'(qp_a >> DIV_SHIFT);
      end
      OP_MUL: begin
        ww       <= 64'(spd_abs) * 64'(spd_abs);
        lim_prod <= 64'({1'b0, ar} + 19'd1) * 64'({accel, 1'b0});
      end
      OP_UPDATE: begin
        p_cmd     <= new34[31:0];
        p_arrived <= arrive;
      end
      OP_PUBLISH: begin
        angular_speed_cmd <= p_cmd;
        heading           <= head;
        angle_remaining   <= rem;
        busy_res          <= rotating;
        arrived           <= p_arrived;
      end
      default: begin
        mv <= mv;
      end
    endcase
  end

endmodule

/* design/trapezoidal_heading_profile_top.sv */
// Top level of the trapezoidal heading profile generator.
//
//   channel   role     handshake         payload
//   in_ch     sink     valid / ready     kind, target_x, target_y
//   out_ch    source   valid / ready     angular_speed_cmd, heading, angle_remaining,
//                                        busy_res, arrived
//   cfg       write    cfg_we            cfg_index, cfg_data
//
// One item at a time. A rotating tick runs up to 40 normalization doubling steps, one CORDIC
// step per cycle, 15 modulo subtract steps and one reciprocal multiply for the divide by the
// sample rate. Start items and idle ticks skip the divide, the product step and the update;
// a target on the ghost skips normalization and CORDIC. A finished result sits in the output
// register; the next item is taken while it waits, and a second finished result stalls until
// the first is taken. Reset is synchronous; nothing else is cleared by a sweep.
`timescale 1ns / 1ps
module trapezoidal_heading_profile_top (
  input  logic        clk,
  input  logic        rst,
  thp_in_if.sink      in_ch,
  thp_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import thp_pkg::*;

  thp_cmd_t    cmd;
  thp_status_t status;

  thp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  thp_datapath u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .cmd               (cmd),
    .status            (status),
    .kind              (in_ch.kind),
    .target_x          (in_ch.target_x),
    .target_y          (in_ch.target_y),
    .angular_speed_cmd (out_ch.angular_speed_cmd),
    .heading           (out_ch.heading),
    .angle_remaining   (out_ch.angle_remaining),
    .busy_res          (out_ch.busy_res),
    .arrived           (out_ch.arrived)
  );

endmodule
